@@ rtl/epool_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// epool_pkg
// Shared constants, codes and helper functions for the entropy pool.
// ----------------------------------------------------------------------------
package epool_pkg;

  localparam int POOL_DEPTH     = 48;
  localparam int TICKS_PER_BYTE = 13;
  localparam int PTR_W          = $clog2(POOL_DEPTH);
  localparam int TICK_W         = 4;
  localparam int LEVEL_W        = 6;

  // operation codes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_READ_BYTE = 2'd1;
  localparam logic [1:0] OP_READ_BIT  = 2'd2;
  localparam logic [1:0] OP_DESKEW    = 2'd3;

  // status codes
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_DATA  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;

  function automatic logic [7:0] bitrev8(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = x[7-i];
    end
    return r;
  endfunction

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(POOL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // (a + b) mod POOL_DEPTH, both operands below POOL_DEPTH
  function automatic ptr_t ptr_add(input ptr_t a, input ptr_t b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W+1)'(POOL_DEPTH)) begin
      s = s - (PTR_W+1)'(POOL_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // occupancy of the ring from write and read pointers
  function automatic logic [LEVEL_W-1:0] ring_level(input ptr_t wp, input ptr_t rp);
    logic [PTR_W:0] d;
    d = {1'b0, wp} - {1'b0, rp};
    if (wp < rp) begin
      d = d + (PTR_W+1)'(POOL_DEPTH);
    end
    return LEVEL_W'(d);
  endfunction

endpackage
`default_nettype wire

@@ rtl/entropy_pool_with_deskew.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// entropy_pool_with_deskew
// Entropy harvester: tick mixer, 48-byte ring pool, bit reader and
// von Neumann deskew stage, one command transaction per cycle while busy is low.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  -------   ----------------   -------------------------------------------
//  command   start / busy       opcode, timer_sample, adc_first, adc_second
//  result    done (strobe)      status, data, level
//  config    cfg_we             cfg_wdata (enable)
//
// A command transaction is taken on a rising edge with start high and busy
// low. Its result is launched at the next edge and held for exactly one
// cycle, marked by done; every command gives exactly one result.
// A new command can follow on every cycle while busy is low: the command is
// registered, worked combinationally against the pool state, and the result
// is registered.
// busy is high through reset and drops at the first edge that sees rst low.
// The result side has no stall; the receiver must take each result.
// Synchronous active-high reset clears all control state; pool entries that
// were never written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module entropy_pool_with_deskew
  import epool_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [7:0]         timer_sample,
  input  wire logic [7:0]         adc_first,
  input  wire logic [7:0]         adc_second,
  output      logic               done,
  output      logic [1:0]         status,
  output      logic [7:0]         data,
  output      logic [LEVEL_W-1:0] level
);

  // --------------------------------------------------------------------------
  // Command register
  // --------------------------------------------------------------------------
  logic       item_valid;
  logic [1:0] item_op;
  logic [7:0] item_timer;
  logic [7:0] item_adc_a;
  logic [7:0] item_adc_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      item_valid <= 1'b0;
    end else begin
      busy       <= 1'b0;
      item_valid <= start && !busy;
    end
    item_op    <= opcode;
    item_timer <= timer_sample;
    item_adc_a <= adc_first;
    item_adc_b <= adc_second;
  end

  // --------------------------------------------------------------------------
  // Block state
  // --------------------------------------------------------------------------
  logic              enable;
  logic [7:0]        mixer, mixer_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  ptr_t              read_pointer, read_pointer_next;
  ptr_t              write_pointer, write_pointer_next;
  ptr_t              fold_offset, fold_offset_next;
  logic [7:0]        bit_source, bit_source_next;
  logic [3:0]        bit_position, bit_position_next;
  logic [7:0]        deskew_byte, deskew_byte_next;
  logic [2:0]        deskew_count, deskew_count_next;
  logic [POOL_DEPTH-1:0] valid;

  // pool write port
  logic       pool_we;
  ptr_t       pool_waddr;
  logic [7:0] pool_wdata;

  // result of the command in flight
  logic [1:0] res_status;
  logic [7:0] res_data;

  // --------------------------------------------------------------------------
  // Pool memory. Read addresses are the pointers of the next state, so the
  // registered read data lines up with the next command. A write to the
  // address being fetched is caught by the bypass registers.
  // --------------------------------------------------------------------------
  ptr_t       pop_raddr, fold_raddr;
  logic [7:0] pop_dout, fold_dout;
  logic       pop_hit, fold_hit;
  logic [7:0] pop_byp, fold_byp;
  logic [7:0] pop_rd, fold_rd;
  ptr_t       fold_addr;

  epool_ram #(
    .WIDTH (8),
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk     (clk),
    .we      (pool_we),
    .waddr   (pool_waddr),
    .wdata   (pool_wdata),
    .raddr_a (pop_raddr),
    .rdata_a (pop_dout),
    .raddr_b (fold_raddr),
    .rdata_b (fold_dout)
  );

  assign pop_raddr  = rst ? '0 : read_pointer_next;
  assign fold_raddr = rst ? '0 : ptr_add(write_pointer_next, fold_offset_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_hit  <= 1'b0;
      fold_hit <= 1'b0;
    end else begin
      pop_hit  <= pool_we && (pool_waddr == pop_raddr);
      fold_hit <= pool_we && (pool_waddr == fold_raddr);
    end
    pop_byp  <= pool_wdata;
    fold_byp <= pool_wdata;
  end

  assign fold_addr = ptr_add(write_pointer, fold_offset);
  assign pop_rd    = pop_hit ? pop_byp : pop_dout;
  // slot never written yet reads as zero through its valid bit
  assign fold_rd   = !valid[fold_addr] ? 8'h00 : (fold_hit ? fold_byp : fold_dout);

  // --------------------------------------------------------------------------
  // Ring status
  // --------------------------------------------------------------------------
  logic empty, full;
  assign empty = (write_pointer == read_pointer);
  assign full  = (read_pointer == ptr_inc(write_pointer));

  // --------------------------------------------------------------------------
  // Command execution
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0] mix_new;
    logic [7:0] byte_new;
    logic       bit_a;
    logic       bit_b;

    mixer_next         = mixer;
    tick_count_next    = tick_count;
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    fold_offset_next   = fold_offset;
    bit_source_next    = bit_source;
    bit_position_next  = bit_position;
    deskew_byte_next   = deskew_byte;
    deskew_count_next  = deskew_count;
    pool_we            = 1'b0;
    pool_waddr         = write_pointer;
    pool_wdata         = mixer;
    res_status         = ST_NONE;
    res_data           = 8'h00;
    mix_new  = {mixer[6:0], mixer[7]} ^ item_timer ^ bitrev8(item_adc_a ^ item_adc_b);
    byte_new = 8'h00;
    bit_a    = 1'b0;
    bit_b    = 1'b0;

    if (item_valid && !rst) begin
      case (item_op)
        OP_TICK: begin
          if (enable) begin
            mixer_next = mix_new;
            if (tick_count == TICK_W'(TICKS_PER_BYTE - 1)) begin
              tick_count_next = '0;
              pool_we         = 1'b1;
              if (full) begin
                // ring full: fold into a rotating slot
                pool_waddr       = fold_addr;
                pool_wdata       = fold_rd ^ mix_new;
                fold_offset_next = ptr_inc(fold_offset);
              end else begin
                pool_waddr         = write_pointer;
                pool_wdata         = mix_new;
                write_pointer_next = ptr_inc(write_pointer);
              end
            end else begin
              tick_count_next = tick_count + TICK_W'(1);
            end
          end
        end
        OP_READ_BYTE: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_status        = ST_DATA;
            res_data          = pop_rd;
            read_pointer_next = ptr_inc(read_pointer);
          end
        end
        OP_READ_BIT: begin
          if (bit_position[3]) begin
            if (empty) begin
              res_status = ST_EMPTY;
            end else begin
              res_status        = ST_DATA;
              res_data          = {7'b0, pop_rd[0]};
              bit_source_next   = pop_rd;
              bit_position_next = 4'd1;
              read_pointer_next = ptr_inc(read_pointer);
            end
          end else begin
            res_status        = ST_DATA;
            res_data          = {7'b0, bit_source[bit_position[2:0]]};
            bit_position_next = bit_position + 4'd1;
          end
        end
        OP_DESKEW: begin
          if (bit_position >= 4'd7 && empty) begin
            res_status = ST_EMPTY;
          end else begin
            if (bit_position[3]) begin
              bit_a             = pop_rd[0];
              bit_b             = pop_rd[1];
              bit_source_next   = pop_rd;
              bit_position_next = 4'd2;
              read_pointer_next = ptr_inc(read_pointer);
            end else if (bit_position == 4'd7) begin
              // last bit of the old byte, first bit of a fresh one
              bit_a             = bit_source[7];
              bit_b             = pop_rd[0];
              bit_source_next   = pop_rd;
              bit_position_next = 4'd1;
              read_pointer_next = ptr_inc(read_pointer);
            end else begin
              bit_a             = bit_source[bit_position[2:0]];
              bit_b             = bit_source[bit_position[2:0] + 3'd1];
              bit_position_next = bit_position + 4'd2;
            end
            if (bit_a != bit_b) begin
              byte_new = deskew_byte | (8'(bit_a) << deskew_count);
              if (deskew_count == 3'd7) begin
                res_status        = ST_DATA;
                res_data          = byte_new;
                deskew_byte_next  = 8'h00;
                deskew_count_next = 3'd0;
              end else begin
                deskew_byte_next  = byte_new;
                deskew_count_next = deskew_count + 3'd1;
              end
            end
          end
        end
        default: begin
          res_status = ST_NONE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      mixer         <= 8'h00;
      tick_count    <= '0;
      read_pointer  <= '0;
      write_pointer <= '0;
      fold_offset   <= '0;
      bit_source    <= 8'h00;
      bit_position  <= 4'd8;
      deskew_byte   <= 8'h00;
      deskew_count  <= 3'd0;
      valid         <= '0;
      done          <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_wdata;
      end
      mixer         <= mixer_next;
      tick_count    <= tick_count_next;
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      fold_offset   <= fold_offset_next;
      bit_source    <= bit_source_next;
      bit_position  <= bit_position_next;
      deskew_byte   <= deskew_byte_next;
      deskew_count  <= deskew_count_next;
      if (pool_we) begin
        valid[pool_waddr] <= 1'b1;
      end
      done <= item_valid;
    end
    status <= res_status;
    data   <= res_data;
    level  <= ring_level(write_pointer_next, read_pointer_next);
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // every accepted transaction yields its result strobe
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result strobe missing for accepted transaction");

  // data is zero unless the result carries data
  assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DATA) |-> (data == 8'h00))
    else $error("data nonzero without valid status");

  // reported level stays within the ring capacity
  assert property (@(posedge clk) disable iff (rst)
    done |-> (level < LEVEL_W'(POOL_DEPTH)))
    else $error("level out of range");

  // a ring that was empty and saw a byte read reports empty
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && empty && item_op == OP_READ_BYTE) |=> (status == ST_EMPTY))
    else $error("byte read on empty pool not reported as empty");

  // bit position never runs past the refill mark
  assert property (@(posedge clk) disable iff (rst)
    bit_position <= 4'd8)
    else $error("bit position out of range");

endmodule
`default_nettype wire

@@ rtl/epool_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// epool_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module epool_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output      logic [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output      logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ tb/entropy_pool_with_deskew_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// entropy_pool_with_deskew_test
// Self-checking bench for the entropy pool: directed rows, then random command
// phases under several enable settings, each result checked against an
// in-bench model of the mixer, ring, bit reader and deskew stage or a row's literal.
// ----------------------------------------------------------------------------
module entropy_pool_with_deskew_test;
  import epool_pkg::*;

  // one result transaction as seen on the result ports
  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         data;
    logic [LEVEL_W-1:0] level;
  } outcome_t;

  // directed row: either an enable write or a command with optional literal result
  typedef struct packed {
    logic       cfg;
    logic       en_val;
    logic [1:0] op;
    logic [7:0] tmr;
    logic [7:0] adc_a;
    logic [7:0] adc_b;
    logic       typed;
    outcome_t   want;
  } step_row_t;

  localparam outcome_t NO_RESULT   = '{ST_NONE,  8'h00, 6'd0};
  localparam outcome_t EMPTY_FLOOR = '{ST_EMPTY, 8'h00, 6'd0};

  // Reset state first (enable off), then thirteen ticks to land exactly one
  // byte, then walk the bit reader down to position 7 so the deskew step must
  // pop from an empty ring.
  localparam step_row_t DIRECTED [26] = '{
    '{1'b0, 1'b0, OP_READ_BYTE, 8'h00, 8'h00, 8'h00, 1'b1, EMPTY_FLOOR},
    '{1'b0, 1'b0, OP_READ_BIT,  8'h00, 8'h00, 8'h00, 1'b1, EMPTY_FLOOR},
    '{1'b0, 1'b0, OP_DESKEW,    8'h00, 8'h00, 8'h00, 1'b1, EMPTY_FLOOR},
    '{1'b0, 1'b0, OP_TICK,      8'hff, 8'hff, 8'h00, 1'b1, NO_RESULT},
    '{1'b1, 1'b1, OP_TICK,      8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'hff, 8'hff, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'hff, 8'h00, 8'hff, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'h00, 8'hff, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'h55, 8'haa, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'haa, 8'h55, 8'hff, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'h0f, 8'hf0, 8'h0f, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'hf0, 8'h0f, 8'hf0, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'h01, 8'h80, 8'h7f, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'h80, 8'h01, 8'hfe, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'h3c, 8'hc3, 8'h5a, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'hc3, 8'h3c, 8'ha5, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_TICK,      8'h7e, 8'h81, 8'h18, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_READ_BIT,  8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_DESKEW,    8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_DESKEW,    8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_READ_BIT,  8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_READ_BIT,  8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 1'b0, OP_DESKEW,    8'h00, 8'h00, 8'h00, 1'b1, EMPTY_FLOOR},
    '{1'b0, 1'b0, OP_READ_BYTE, 8'h00, 8'h00, 8'h00, 1'b1, EMPTY_FLOOR},
    '{1'b1, 1'b0, OP_TICK,      8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT}
  };

  // random phases: enable setting, percent of ticks, command count
  localparam int NUM_PHASES = 5;
  localparam int PHASE_EN   [NUM_PHASES] = '{1, 0, 1, 0, 1};
  localparam int PHASE_TICKS[NUM_PHASES] = '{100, 10, 60, 0, 80};
  localparam int PHASE_LEN  [NUM_PHASES] = '{700, 250, 180, 50, 70};

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       start;
  logic       busy;
  logic [1:0] opcode;
  logic [7:0] timer_sample;
  logic [7:0] adc_first;
  logic [7:0] adc_second;
  logic       done;
  logic [1:0] status;
  logic [7:0] data;
  logic [LEVEL_W-1:0] level;

  // literal result riding along with the command in flight (directed rows)
  logic       row_typed;
  outcome_t   row_want;

  outcome_t   outcomes_due [$];
  int         errs = 0;
  bit         steady;

  // shadow of the harvester state
  logic [7:0] ring [POOL_DEPTH];
  ptr_t       rd_ptr, wr_ptr, fold_ofs;
  logic [7:0] mix, bit_src, dsk_byte;
  logic [3:0] tick_cnt, bit_pos;
  logic [2:0] dsk_cnt;
  logic       gate_on;

  entropy_pool_with_deskew dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .timer_sample(timer_sample),
    .adc_first   (adc_first),
    .adc_second  (adc_second),
    .done        (done),
    .status      (status),
    .data        (data),
    .level       (level)
  );

  always #5 clk = ~clk;

  // Long enough for the slowest legal run several times over.
  initial begin
    #5ms;
    $display("entropy_pool_with_deskew_test NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- model --

  function automatic ptr_t ring_wrap(input int v);
    return ptr_t'(v % POOL_DEPTH);
  endfunction

  function automatic logic [LEVEL_W-1:0] fill_count();
    return LEVEL_W'((int'(wr_ptr) + POOL_DEPTH - int'(rd_ptr)) % POOL_DEPTH);
  endfunction

  function automatic logic [7:0] pop_ring();
    logic [7:0] v;
    v = ring[rd_ptr];
    rd_ptr = ring_wrap(int'(rd_ptr) + 1);
    return v;
  endfunction

  // Bits are handed out LSB first; position 8 means a fresh byte is needed.
  function automatic logic next_bit();
    logic b;
    if (bit_pos > 4'd7) begin
      bit_src = pop_ring();
      bit_pos = 4'd0;
    end
    b = bit_src[bit_pos[2:0]];
    bit_pos = bit_pos + 4'd1;
    return b;
  endfunction

  function automatic void stir(input logic [7:0] t, input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x, rev;
    ptr_t       nxt;
    x = a ^ b;
    for (int i = 0; i < 8; i++) rev[i] = x[7-i];
    mix = {mix[6:0], mix[7]} ^ t ^ rev;
    tick_cnt = tick_cnt + 4'd1;
    if (tick_cnt == 4'(TICKS_PER_BYTE)) begin
      tick_cnt = 4'd0;
      nxt = ring_wrap(int'(wr_ptr) + 1);
      if (nxt == rd_ptr) begin
        // ring full: fold into a rotating slot instead of pushing
        ring[ring_wrap(int'(wr_ptr) + int'(fold_ofs))] ^= mix;
        fold_ofs = ring_wrap(int'(fold_ofs) + 1);
      end else begin
        ring[wr_ptr] = mix;
        wr_ptr = nxt;
      end
    end
  endfunction

  function automatic outcome_t entropy_step(input logic [1:0] op, input logic [7:0] t,
                                            input logic [7:0] a, input logic [7:0] b);
    outcome_t r;
    logic     empty, first, second;
    r = NO_RESULT;
    empty = (fill_count() == '0);
    case (op)
      OP_TICK: begin
        if (gate_on) stir(t, a, b);
      end
      OP_READ_BYTE: begin
        if (empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.data   = pop_ring();
          r.status = ST_DATA;
        end
      end
      OP_READ_BIT: begin
        if (bit_pos > 4'd7 && empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.data   = {7'd0, next_bit()};
          r.status = ST_DATA;
        end
      end
      default: begin
        // deskew draws two bits; at position 7 the second one needs a pop
        if (bit_pos >= 4'd7 && empty) begin
          r.status = ST_EMPTY;
        end else begin
          first  = next_bit();
          second = next_bit();
          if (first != second) begin
            dsk_byte[dsk_cnt] = first;
            if (dsk_cnt == 3'd7) begin
              r.data   = dsk_byte;
              r.status = ST_DATA;
              dsk_byte = 8'h00;
              dsk_cnt  = 3'd0;
            end else begin
              dsk_cnt = dsk_cnt + 3'd1;
            end
          end
        end
      end
    endcase
    r.level = fill_count();
    return r;
  endfunction

  // ------------------------------------------------------------- checking --

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // One process does both the scoreboard pop and the push, so ordering inside
  // an edge never matters. Results are retired before a new command is
  // predicted; latency keeps the two apart anyway.
  always @(posedge clk) begin
    outcome_t got, want;
    if (done) begin
      got = '{status, data, level};
      if (outcomes_due.size() == 0) begin
        errs++;
        $display("%0t: unexpected result transaction, expected none, got %h", $time, got);
      end else begin
        want = outcomes_due.pop_front();
        check_field("status", want.status, got.status);
        check_field("data",   want.data,   got.data);
        check_field("level",  want.level,  got.level);
      end
    end
    if (cfg_we) gate_on = cfg_wdata;
    if (start && !busy) begin
      want = entropy_step(opcode, timer_sample, adc_first, adc_second);
      if (row_typed) want = row_want;
      outcomes_due.push_back(want);
    end
  end

  // -------------------------------------------------------------- driving --

  // Present one command transaction at the falling edge and hold it until
  // busy is low at a rising edge.
  task automatic send(input logic [1:0] op, input logic [7:0] t, input logic [7:0] a,
                      input logic [7:0] b, input logic typed, input outcome_t want);
    @(negedge clk);
    start        <= 1'b1;
    opcode       <= op;
    timer_sample <= t;
    adc_first    <= a;
    adc_second   <= b;
    row_typed    <= typed;
    row_want     <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // stop sending until every result transaction has come back
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_enable(input logic v);
    settle();
    idle(3);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly back-to-back, some short gaps, rarely a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // uniform byte with the two extremes weighted up
  function automatic logic [7:0] noisy_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [1:0] op;
    // shadow reset state; bit position 8 forces a refill on first use
    foreach (ring[i]) ring[i] = 8'h00;
    rd_ptr = '0; wr_ptr = '0; fold_ofs = '0;
    mix = 8'h00; bit_src = 8'h00; dsk_byte = 8'h00;
    tick_cnt = 4'd0; bit_pos = 4'd8; dsk_cnt = 3'd0;
    gate_on = 1'b0;
    steady = 1'b0;

    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = 1'b0; start = 1'b0;
    opcode = OP_TICK; timer_sample = 8'h00; adc_first = 8'h00; adc_second = 8'h00;
    row_typed = 1'b0; row_want = NO_RESULT;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows; commands go back to back, enable writes wait for the results
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg)
        write_enable(DIRECTED[i].en_val);
      else
        send(DIRECTED[i].op, DIRECTED[i].tmr, DIRECTED[i].adc_a, DIRECTED[i].adc_b,
             DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases: a long enabled fill that overflows into folding, a
    // disabled drain that hits the empty paths, then mixed traffic.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_enable(PHASE_EN[p][0]);
      for (int n = 0; n < PHASE_LEN[p]; n++) begin
        if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 79) == 0)
          settle();
        else
          idle(pick_gap());
        if ($urandom_range(0, 99) < PHASE_TICKS[p])
          op = OP_TICK;
        else
          op = 2'($urandom_range(1, 3));
        send(op, noisy_byte(), noisy_byte(), noisy_byte(), 1'b0, NO_RESULT);
      end
    end

    settle();
    idle(10);
    if (errs == 0) begin
      $display("entropy_pool_with_deskew_test OK");
    end else begin
      $display("entropy_pool_with_deskew_test NOT OK");
    end
    $finish;
  end

endmodule
